[rtl/sha_pkg.sv]
package sha_pkg;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       close;
    } sha_cmd_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

endpackage

[rtl/sha_cmd_fifo.sv]
module sha_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sha_pkg::sha_cmd_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output sha_pkg::sha_cmd_t rd_data,
    output logic              empty
);
    import sha_pkg::*;

    localparam int AW = $clog2(DEPTH);

    sha_cmd_t        mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
        end
    end

endmodule

[rtl/sha_core.sv]
module sha_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  sha_pkg::sha_cmd_t cmd,
    output logic              cmd_take,
    output logic [31:0]       digest_word,
    output logic [2:0]        word_index,
    output logic              last_word,
    output logic              empty,
    input  logic              pop
);
    import sha_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_ZERO  = 7'b0000100,
        ST_LEN   = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_ADD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t        state_reg;
    logic [31:0]   blk_reg [16];
    logic [5:0]    fill_reg;
    logic [60:0]   len_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    rnd_reg;
    logic          final_reg;
    logic [2:0]    out_idx_reg;
    logic          closing_reg;
    logic          spill_reg;

    logic [31:0] w_cur, s1, ch, t1, s0, mj, a15, a2, x0, x1;
    logic [63:0] bits;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    assign bits = {len_reg, 3'b000};
    assign a15  = w_reg[1];
    assign a2   = w_reg[14];
    assign x0   = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
    assign x1   = rotr(a2, 17) ^ rotr(a2, 19) ^ (a2 >> 10);
    assign w_cur = (rnd_reg < 6'd16) ? blk_reg[rnd_reg[3:0]]
                                     : w_reg[0] + x0 + w_reg[9] + x1;
    assign s1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
    assign ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1 = v_reg[7] + s1 + ch + ROUND_K[rnd_reg] + w_cur;
    assign s0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
    assign mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);

    assign cmd_take    = (state_reg == ST_IDLE) && cmd_valid;
    assign empty       = (state_reg != ST_OUT);
    assign digest_word = h_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.has_byte)
                begin
                    blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= cmd.data;
                end
                if (cmd_valid)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                end
            end
            ST_PAD:
            begin
                blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= PAD_BYTE;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_ZERO:
            begin
                blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= 8'h00;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_LEN:
            begin
                blk_reg[14] <= bits[63:32];
                blk_reg[15] <= bits[31:0];
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= w_cur;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + s0 + mj;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            rnd_reg     <= '0;
            final_reg   <= 1'b0;
            closing_reg <= 1'b0;
            spill_reg   <= 1'b0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= IV[i];
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        closing_reg <= cmd.close;
                        rnd_reg     <= '0;
                        final_reg   <= 1'b0;
                        if (cmd.has_byte)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            len_reg  <= len_reg + 1'b1;
                            if (fill_reg == 6'd63)
                            begin
                                state_reg <= ST_ROUND;
                            end
                            else if (cmd.close)
                            begin
                                state_reg <= ST_PAD;
                            end
                        end
                        else if (cmd.close)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    closing_reg <= 1'b0;
                    fill_reg    <= fill_reg + 1'b1;
                    rnd_reg     <= '0;
                    if (fill_reg == 6'd63)
                    begin
                        final_reg <= 1'b0;
                        spill_reg <= 1'b1;
                        state_reg <= ST_ROUND;
                    end
                    else if (fill_reg == LEN_START - 6'd1)
                    begin
                        state_reg <= ST_LEN;
                    end
                    else
                    begin
                        state_reg <= ST_ZERO;
                    end
                end
                ST_ZERO:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    rnd_reg  <= '0;
                    if (fill_reg == 6'd63)
                    begin
                        final_reg <= 1'b0;
                        spill_reg <= 1'b1;
                        state_reg <= ST_ROUND;
                    end
                    else if (fill_reg == LEN_START - 6'd1)
                    begin
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN:
                begin
                    fill_reg  <= '0;
                    rnd_reg   <= '0;
                    final_reg <= 1'b1;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    fill_reg <= '0;
                    if (final_reg)
                    begin
                        out_idx_reg <= '0;
                        state_reg   <= ST_OUT;
                    end
                    else if (closing_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else if (spill_reg)
                    begin
                        spill_reg <= 1'b0;
                        state_reg <= ST_ZERO;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (pop)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == 3'd7)
                        begin
                            len_reg   <= '0;
                            final_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= IV[i];
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/sha256_message_digest.sv]
// SHA-256 message hasher.
// Input queue: push an item with data_byte/byte_valid/end_of_message while
// full is low. Each item may carry one byte and may close the message.
// Items land in a QUEUE_DEPTH-entry command queue (four by default); the hash core drains it.
// Result queue: while empty is low, digest_word/word_index/last_word show
// the next digest word; pop takes it. Eight words leave per message,
// index 0 first, last_word set on index 7.
// Block flow: the core takes bytes while idle; every full 64-byte block
// then runs 64 rounds of the single round unit plus the chain add, and no
// byte is taken meanwhile. Closing writes the pad byte and zero bytes up
// to byte 55, then the length, then compresses the last block. When the pad
// spills past byte 55, the rest of that block is zeroed and compressed,
// then 56 zero bytes, the length and the last compression follow.
// Reset loads the initial hash values and empties both queues.
// A stalled receiver holds the current word; the core waits, and the input
// queue then fills and raises full.
module sha256_message_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    input  logic        push,
    output logic        full,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word,
    output logic        empty,
    input  logic        pop
);
    import sha_pkg::*;

    sha_cmd_t wr_cmd;
    sha_cmd_t rd_cmd;
    logic     q_empty;
    logic     take;

    assign wr_cmd = '{data: data_byte, has_byte: byte_valid, close: end_of_message};

    sha_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(wr_cmd), .full(full),
        .rd_en(take), .rd_data(rd_cmd), .empty(q_empty)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(!q_empty), .cmd(rd_cmd), .cmd_take(take),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .empty(empty), .pop(pop)
    );

endmodule
